// ----- src/crcdf_pkg.sv -----
// Shared types, register indexes and the CRC16 byte update for the packet deframer.
// No dependencies; imported by crc16_packet_deframer.
package crcdf_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int OUT_DAT_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 3'd3;

  localparam logic [7:0]  HEADER_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  HEADER_SECOND_RST = 8'h55;
  localparam logic [7:0]  MAX_PAYLOAD_RST   = 8'd64;
  localparam logic [15:0] TIMEOUT_RST       = 16'd100;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_LEN_ERR = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_HDR2 = 3'd1,
    PH_TYPE = 3'd2,
    PH_LEN  = 3'd3,
    PH_BODY = 3'd4,
    PH_CRCH = 3'd5,
    PH_CRCL = 3'd6
  } phase_t;

  // CRC16-CCITT, MSB first, one byte per call (eight narrow shift/xor steps).
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- src/crc16_packet_deframer.sv -----
// Top level of the byte-serial packet deframer with CRC16 check.
// Depends on crcdf_pkg (types, register indexes, CRC byte update).
//
// The block takes one transfer per cycle on the input stream: tuser = 0 carries
// a received byte in tdata, tuser = 1 marks one time tick. It hunts for the
// first header byte, requires the second header byte (a mismatch drops that byte
// and resumes hunting), then takes a type byte and a length byte. Each payload
// byte leaves as one output transfer (tuser = 0) with its index, the frame type
// and length. A frame ends with one transfer (tuser = 1) whose status is ok, CRC
// mismatch, length too long (length above max_payload; nothing else is sent) or
// timeout (a tick arriving once timeout_ticks ticks have been counted since the
// length byte). The CRC is CRC16-CCITT (poly 0x1021, init 0xFFFF, no reflection)
// over type, length and payload, received big-endian. Every item passes through
// the input register and then the result register, and one item is accepted per
// cycle as long as the result register drains; the byte-wide CRC update between
// those registers sets the critical path. Write the configuration registers only
// while no frame traffic is in flight.
module crc16_packet_deframer #(
  parameter logic [7:0]  HEADER_FIRST_INIT  = crcdf_pkg::HEADER_FIRST_RST,
  parameter logic [7:0]  HEADER_SECOND_INIT = crcdf_pkg::HEADER_SECOND_RST,
  parameter logic [7:0]  MAX_PAYLOAD_INIT   = crcdf_pkg::MAX_PAYLOAD_RST,
  parameter logic [15:0] TIMEOUT_INIT       = crcdf_pkg::TIMEOUT_RST
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] rx_byte
  input  logic                              in_tuser,   // cmd
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] out_byte, [15:8] byte_index, [23:16] frame_type,
  // [31:24] frame_length, [33:32] status, [39:34] zero
  output logic [crcdf_pkg::OUT_DAT_W-1:0]   out_tdata,
  output logic                              out_tuser,  // out_kind
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crcdf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crcdf_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import crcdf_pkg::*;

  // configuration registers
  logic [7:0]  header_first_r, header_second_r, max_payload_r;
  logic [15:0] timeout_ticks_r;

  // input register
  logic        in_valid_r;
  logic        in_cmd_r;
  logic [7:0]  in_byte_r;

  // frame state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;
  logic [15:0] ticks_r, ticks_nxt;

  // result register
  logic        out_valid_r;
  logic        out_kind_r, out_kind_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic [7:0]  out_idx_r, out_idx_nxt;
  logic [7:0]  out_type_r, out_type_nxt;
  logic [7:0]  out_len_r, out_len_nxt;
  status_t     out_status_r, out_status_nxt;
  logic        emit;

  logic        out_free;
  logic        advance;
  logic        in_body;
  logic [7:0]  count_inc;
  logic [15:0] crc_upd;

  assign cfg_ready = 1'b1;

  // Advance the held item whenever the result register can take a transfer.
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  assign in_body   = (phase_r == PH_BODY) || (phase_r == PH_CRCH) || (phase_r == PH_CRCL);
  assign count_inc = count_r + 8'd1;
  assign crc_upd   = crc16_byte((phase_r == PH_TYPE) ? CRC_INIT : crc_r, in_byte_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_first_r  <= HEADER_FIRST_INIT;
      header_second_r <= HEADER_SECOND_INIT;
      max_payload_r   <= MAX_PAYLOAD_INIT;
      timeout_ticks_r <= TIMEOUT_INIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEADER_FIRST:  header_first_r  <= cfg_data[7:0];
        CFG_HEADER_SECOND: header_second_r <= cfg_data[7:0];
        CFG_MAX_PAYLOAD:   max_payload_r   <= cfg_data[7:0];
        CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (in_cmd_r == CMD_TICK) begin
      if (in_body && (ticks_r >= timeout_ticks_r)) begin
        phase_nxt = PH_HUNT;
      end
    end else begin
      unique case (phase_r)
        PH_HUNT: if (in_byte_r == header_first_r) phase_nxt = PH_HDR2;
        PH_HDR2: phase_nxt = (in_byte_r == header_second_r) ? PH_TYPE : PH_HUNT;
        PH_TYPE: phase_nxt = PH_LEN;
        PH_LEN: begin
          if (in_byte_r > max_payload_r) begin
            phase_nxt = PH_HUNT;
          end else if (in_byte_r == 8'd0) begin
            phase_nxt = PH_CRCH;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: if (count_inc >= len_r) phase_nxt = PH_CRCH;
        PH_CRCH: phase_nxt = PH_CRCL;
        PH_CRCL: phase_nxt = PH_HUNT;
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  // Frame datapath and result generation.
  always_comb begin
    type_nxt       = type_r;
    len_nxt        = len_r;
    count_nxt      = count_r;
    crc_nxt        = crc_r;
    crc_hi_nxt     = crc_hi_r;
    ticks_nxt      = ticks_r;
    emit           = 1'b0;
    out_kind_nxt   = KIND_END;
    out_byte_nxt   = 8'd0;
    out_idx_nxt    = 8'd0;
    out_type_nxt   = type_r;
    out_len_nxt    = len_r;
    out_status_nxt = ST_OK;
    if (in_cmd_r == CMD_TICK) begin
      if (in_body) begin
        if (ticks_r >= timeout_ticks_r) begin
          emit           = 1'b1;
          out_status_nxt = ST_TIMEOUT;
        end else begin
          ticks_nxt = ticks_r + 16'd1;
        end
      end
    end else begin
      unique case (phase_r)
        PH_TYPE: begin
          type_nxt = in_byte_r;
          crc_nxt  = crc_upd;
        end
        PH_LEN: begin
          len_nxt = in_byte_r;
          if (in_byte_r > max_payload_r) begin
            emit           = 1'b1;
            out_len_nxt    = in_byte_r;
            out_status_nxt = ST_LEN_ERR;
          end else begin
            crc_nxt   = crc_upd;
            count_nxt = 8'd0;
            ticks_nxt = 16'd0;
          end
        end
        PH_BODY: begin
          emit         = 1'b1;
          out_kind_nxt = KIND_PAYLOAD;
          out_byte_nxt = in_byte_r;
          out_idx_nxt  = count_r;
          crc_nxt      = crc_upd;
          count_nxt    = count_inc;
        end
        PH_CRCH: crc_hi_nxt = in_byte_r;
        PH_CRCL: begin
          emit           = 1'b1;
          out_status_nxt = ({crc_hi_r, in_byte_r} == crc_r) ? ST_OK : ST_CRC_ERR;
        end
        default: ;  // header bytes touch no datapath state
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_HUNT;
      type_r      <= 8'd0;
      len_r       <= 8'd0;
      count_r     <= 8'd0;
      crc_r       <= CRC_INIT;
      crc_hi_r    <= 8'd0;
      ticks_r     <= 16'd0;
    end else begin
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end

      if (advance) begin
        out_valid_r <= emit;
        phase_r     <= phase_nxt;
        type_r      <= type_nxt;
        len_r       <= len_nxt;
        count_r     <= count_nxt;
        crc_r       <= crc_nxt;
        crc_hi_r    <= crc_hi_nxt;
        ticks_r     <= ticks_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: hold the item and the result until they advance.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_cmd_r  <= in_tuser;
      in_byte_r <= in_tdata;
    end
    if (advance && emit) begin
      out_kind_r   <= out_kind_nxt;
      out_byte_r   <= out_byte_nxt;
      out_idx_r    <= out_idx_nxt;
      out_type_r   <= out_type_nxt;
      out_len_r    <= out_len_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {6'd0, out_status_r, out_len_r, out_type_r, out_idx_r, out_byte_r};

  // A payload transfer never carries an error status and stays inside its frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == KIND_PAYLOAD) |-> (out_status_r == ST_OK)
                                                   && (out_idx_r < out_len_r))
    else $error("payload transfer with bad status or index");

  // Every frame end returns the phase machine to hunting.
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && emit && (out_kind_nxt == KIND_END) |=> (phase_r == PH_HUNT))
    else $error("frame end did not return to hunting");

  // The input side only stalls while an item is held.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a held item");

  // A held item is never overwritten before it advances.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_byte_r) && $stable(in_cmd_r))
    else $error("held input item lost");

endmodule
